FILE: hw/rtl/discrete_log_bsgs_macros.svh
// Assertion macros shared by the checker of the discrete-log block.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef DISCRETE_LOG_BSGS_MACROS_SVH
`define DISCRETE_LOG_BSGS_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent
`define DLB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("discrete_log_bsgs assertion failed");

// Consequence must hold in the cycle after the antecedent
`define DLB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("discrete_log_bsgs assertion failed");

`endif

FILE: hw/rtl/dlb_pkg.sv
// Package for the baby-step giant-step discrete-log block.
// Holds widths, status codes, payload structs and state enums; no dependencies.
package dlb_pkg;

    localparam int MOD_BITS    = 32;
    localparam int TABLE_DEPTH = 65536;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);

    localparam logic [31:0] MOD_MASK = 32'((64'd1 << MOD_BITS) - 64'd1);
    localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;

    // Result status codes
    localparam logic [1:0] ST_FOUND       = 2'd0;
    localparam logic [1:0] ST_NOT_COPRIME = 2'd1;
    localparam logic [1:0] ST_NO_SOLUTION = 2'd2;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] target;
        logic [31:0] modulus;
    } in_item_t;

    typedef struct packed {
        logic [32:0] exponent;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [1:0] {
        TBL_CLEAR,
        TBL_PUT,
        TBL_GET
    } tbl_op_t;

    typedef struct packed {
        logic        start;
        tbl_op_t     op;
        logic [31:0] key;
        logic [15:0] exponent;
    } tbl_req_t;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [15:0] exponent;
    } tbl_resp_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_CLEAR,
        T_HASH,
        T_SLOT,
        T_READ,
        T_CHECK
    } tbl_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GCD_GO,
        S_GCD_WAIT,
        S_REDB_GO,
        S_REDB_WAIT,
        S_REDT_GO,
        S_REDT_WAIT,
        S_SQRT,
        S_CLR_GO,
        S_CLR_WAIT,
        S_PUT_GO,
        S_PUT_WAIT,
        S_BMUL_GO,
        S_BMUL_WAIT,
        S_GF_GO,
        S_GF_WAIT,
        S_GF_CHECK,
        S_GET_GO,
        S_GET_WAIT,
        S_GMUL_GO,
        S_GMUL_WAIT,
        S_PROD,
        S_SUB,
        S_DONE
    } dlb_state_t;

endpackage

FILE: hw/rtl/dlb_remu.sv
// Bit-serial unsigned remainder x mod y, one dividend bit per cycle.
// Stand-alone; no package dependency.
module dlb_remu
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  bit_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;
    logic [31:0] r_reg;
    logic [32:0] trial;
    logic [32:0] diff;

    // Shift in the next dividend bit and subtract the divisor if it fits
    assign trial = {r_reg, x_reg[31]};
    assign diff  = trial - {1'b0, y_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg + 5'd1;
                if (bit_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            x_reg <= x;
            y_reg <= y;
            r_reg <= 32'd0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[30:0], 1'b0};
            r_reg <= (trial >= {1'b0, y_reg}) ? diff[31:0] : trial[31:0];
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

FILE: hw/rtl/dlb_mulmod.sv
// Bit-serial modular multiplier a*b mod p, a doubling phase and an add phase per multiplier bit.
// Stand-alone; b must already be below p.
module dlb_mulmod
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] p,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg;
    logic        done_reg;
    logic        phase_reg;
    logic [4:0]  bit_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] p_reg;
    logic [31:0] r_reg;
    logic [32:0] sum;
    logic [32:0] sum_red;

    // Phase 0 doubles the partial result, phase 1 adds b when the bit is set
    always_comb
    begin
        if (!phase_reg)
            sum = {r_reg, 1'b0};
        else if (a_reg[31])
            sum = {1'b0, r_reg} + {1'b0, b_reg};
        else
            sum = {1'b0, r_reg};
        sum_red = (sum >= {1'b0, p_reg}) ? (sum - {1'b0, p_reg}) : sum;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            bit_reg   <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                bit_reg   <= 5'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd31)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg <= a;
            b_reg <= b;
            p_reg <= p;
            r_reg <= 32'd0;
        end
        else if (busy_reg)
        begin
            r_reg <= sum_red[31:0];
            if (phase_reg)
                a_reg <= {a_reg[30:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

FILE: hw/rtl/dlb_table.sv
// Baby-step hash table: open addressing with linear probing in one RAM.
// Depends on dlb_pkg for depth, hash constant, request/response structs.
module dlb_table
(
    input  logic              clk,
    input  logic              rst_n,
    input  dlb_pkg::tbl_req_t  req,
    output dlb_pkg::tbl_resp_t resp
);

    localparam int IW = dlb_pkg::IDX_BITS;

    dlb_pkg::tbl_state_t state_reg;
    dlb_pkg::tbl_state_t state_next;

    dlb_pkg::tbl_op_t op_reg;
    logic [31:0]      key_reg;
    logic [15:0]      exp_reg;
    logic [31:0]      hprod_reg;
    logic [31:0]      hmix;
    logic [IW-1:0]    slot_reg;
    logic [IW-1:0]    probe_reg;
    logic [IW-1:0]    clr_reg;

    // RAM word: valid, key, exponent
    logic [48:0]      mem [dlb_pkg::TABLE_DEPTH];
    logic [48:0]      rd_data_reg;
    logic             rd_en;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [48:0]      wr_data;

    logic             ent_valid;
    logic             ent_match;
    logic             last_probe;

    assign hmix       = hprod_reg ^ (hprod_reg >> 16);
    assign ent_valid  = rd_data_reg[48];
    assign ent_match  = (rd_data_reg[47:16] == key_reg);
    assign last_probe = (probe_reg == {IW{1'b1}});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dlb_pkg::T_IDLE:
            begin
                if (req.start)
                    state_next = (req.op == dlb_pkg::TBL_CLEAR) ? dlb_pkg::T_CLEAR
                                                                : dlb_pkg::T_HASH;
            end
            dlb_pkg::T_CLEAR:
            begin
                if (clr_reg == {IW{1'b1}})
                    state_next = dlb_pkg::T_IDLE;
            end
            dlb_pkg::T_HASH:  state_next = dlb_pkg::T_SLOT;
            dlb_pkg::T_SLOT:  state_next = dlb_pkg::T_READ;
            dlb_pkg::T_READ:  state_next = dlb_pkg::T_CHECK;
            dlb_pkg::T_CHECK:
            begin
                if (!ent_valid || ent_match || last_probe)
                    state_next = dlb_pkg::T_IDLE;
                else
                    state_next = dlb_pkg::T_READ;
            end
            default: state_next = dlb_pkg::T_IDLE;
        endcase
    end

    // Outputs: RAM strobes and response
    always_comb
    begin
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = slot_reg;
        wr_data       = {1'b1, key_reg, exp_reg};
        resp.done     = 1'b0;
        resp.hit      = 1'b0;
        resp.exponent = rd_data_reg[15:0];
        unique case (state_reg)
            dlb_pkg::T_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = 49'd0;
                if (clr_reg == {IW{1'b1}})
                    resp.done = 1'b1;
            end
            dlb_pkg::T_READ:
                rd_en = 1'b1;
            dlb_pkg::T_CHECK:
            begin
                if (!ent_valid || ent_match)
                begin
                    resp.done = 1'b1;
                    if (op_reg == dlb_pkg::TBL_PUT)
                        wr_en = 1'b1;
                    else
                        resp.hit = ent_valid;
                end
                else if (last_probe)
                    resp.done = 1'b1;
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dlb_pkg::T_IDLE;
        else
            state_reg <= state_next;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            dlb_pkg::T_IDLE:
            begin
                op_reg  <= req.op;
                key_reg <= req.key;
                exp_reg <= req.exponent;
                clr_reg <= '0;
            end
            dlb_pkg::T_CLEAR:
                clr_reg <= clr_reg + 1'b1;
            dlb_pkg::T_HASH:
                hprod_reg <= key_reg * dlb_pkg::HASH_MUL;
            dlb_pkg::T_SLOT:
            begin
                slot_reg  <= hmix[IW-1:0];
                probe_reg <= '0;
            end
            dlb_pkg::T_CHECK:
            begin
                slot_reg  <= slot_reg + 1'b1;
                probe_reg <= probe_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // RAM ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[slot_reg];
    end

endmodule

FILE: hw/rtl/discrete_log_bsgs.sv
// Discrete logarithm by baby-step giant-step: solves base^x = target mod modulus.
// Depends on dlb_pkg, dlb_remu, dlb_mulmod and dlb_table.
//
// One query at a time. A query first runs Euclid's gcd on a bit-serial
// remainder unit (up to about 46 Euclid steps for 32-bit operands), then
// reduces base and target and takes a bit-by-bit square root to get m. Every
// coprime query clears the hash table with a pass over all 65536 entries,
// then makes m table insertions, m products for base^m and up to m lookups
// with products. Each modular product on the serial multiplier takes a
// doubling phase and an add phase per multiplier bit, and each table access
// passes the hash, slot, read and check states, plus a further read and
// check for every probe after a collision.
// A finished result waits in an output register while the next query is taken.
module discrete_log_bsgs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dlb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dlb_pkg::out_item_t out_data
);

    dlb_pkg::dlb_state_t state_reg;
    dlb_pkg::dlb_state_t state_next;

    logic [31:0] base_reg;
    logic [31:0] target_reg;
    logic [31:0] p_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;
    logic [31:0] br_reg;
    logic [31:0] tr_reg;
    logic [31:0] pw_reg;
    logic [31:0] gf_reg;
    logic [16:0] m_reg;
    logic [16:0] cnt_reg;
    logic [15:0] sq_reg;
    logic [3:0]  sqb_reg;
    logic [15:0] hit_reg;
    logic [33:0] prod_reg;
    logic [32:0] res_exp_reg;
    logic [1:0]  res_status_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    dlb_pkg::out_item_t out_data_reg;

    logic        load_out;
    logic [31:0] in_mod;

    // Serial units
    logic        rm_start;
    logic [31:0] rm_x;
    logic [31:0] rm_y;
    logic        rm_done;
    logic [31:0] rm_result;
    logic        mm_start;
    logic [31:0] mm_a;
    logic [31:0] mm_b;
    logic        mm_done;
    logic [31:0] mm_result;
    dlb_pkg::tbl_req_t  tbl_req;
    dlb_pkg::tbl_resp_t tbl_resp;

    // Square-root step
    logic [15:0] sq_try;
    logic [31:0] sq_sq;
    logic [15:0] sq_pick;

    logic        baby_last;

    assign in_mod    = in_data.modulus & dlb_pkg::MOD_MASK;
    assign sq_try    = sq_reg | (16'd1 << sqb_reg);
    assign sq_sq     = sq_try * sq_try;
    assign sq_pick   = (sq_sq <= p_reg) ? sq_try : sq_reg;
    assign baby_last = ((cnt_reg + 17'd1) == m_reg);
    assign load_out  = (state_reg == dlb_pkg::S_DONE) && (!out_valid_reg || out_ready);

    dlb_remu u_remu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rm_start),
        .x      (rm_x),
        .y      (rm_y),
        .done   (rm_done),
        .result (rm_result)
    );

    dlb_mulmod u_mulmod
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .p      (p_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    dlb_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .resp  (tbl_resp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dlb_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = (in_mod == 32'd0) ? dlb_pkg::S_DONE : dlb_pkg::S_GCD_GO;
            end
            dlb_pkg::S_GCD_GO:
            begin
                if (y_reg != 32'd0)
                    state_next = dlb_pkg::S_GCD_WAIT;
                else if (x_reg == 32'd1)
                    state_next = dlb_pkg::S_REDB_GO;
                else
                    state_next = dlb_pkg::S_DONE;
            end
            dlb_pkg::S_GCD_WAIT:  if (rm_done) state_next = dlb_pkg::S_GCD_GO;
            dlb_pkg::S_REDB_GO:   state_next = dlb_pkg::S_REDB_WAIT;
            dlb_pkg::S_REDB_WAIT: if (rm_done) state_next = dlb_pkg::S_REDT_GO;
            dlb_pkg::S_REDT_GO:   state_next = dlb_pkg::S_REDT_WAIT;
            dlb_pkg::S_REDT_WAIT: if (rm_done) state_next = dlb_pkg::S_SQRT;
            dlb_pkg::S_SQRT:      if (sqb_reg == 4'd0) state_next = dlb_pkg::S_CLR_GO;
            dlb_pkg::S_CLR_GO:    state_next = dlb_pkg::S_CLR_WAIT;
            dlb_pkg::S_CLR_WAIT:  if (tbl_resp.done) state_next = dlb_pkg::S_PUT_GO;
            dlb_pkg::S_PUT_GO:    state_next = dlb_pkg::S_PUT_WAIT;
            dlb_pkg::S_PUT_WAIT:
            begin
                if (tbl_resp.done)
                    state_next = baby_last ? dlb_pkg::S_GF_GO : dlb_pkg::S_BMUL_GO;
            end
            dlb_pkg::S_BMUL_GO:   state_next = dlb_pkg::S_BMUL_WAIT;
            dlb_pkg::S_BMUL_WAIT: if (mm_done) state_next = dlb_pkg::S_PUT_GO;
            dlb_pkg::S_GF_GO:     state_next = dlb_pkg::S_GF_WAIT;
            dlb_pkg::S_GF_WAIT:
            begin
                if (mm_done)
                    state_next = baby_last ? dlb_pkg::S_GF_CHECK : dlb_pkg::S_GF_GO;
            end
            dlb_pkg::S_GF_CHECK:
                state_next = (gf_reg == 32'd0) ? dlb_pkg::S_DONE : dlb_pkg::S_GET_GO;
            dlb_pkg::S_GET_GO:    state_next = dlb_pkg::S_GET_WAIT;
            dlb_pkg::S_GET_WAIT:
            begin
                if (tbl_resp.done)
                begin
                    if (tbl_resp.hit)
                        state_next = dlb_pkg::S_PROD;
                    else if (cnt_reg == m_reg)
                        state_next = dlb_pkg::S_DONE;
                    else
                        state_next = dlb_pkg::S_GMUL_GO;
                end
            end
            dlb_pkg::S_GMUL_GO:   state_next = dlb_pkg::S_GMUL_WAIT;
            dlb_pkg::S_GMUL_WAIT: if (mm_done) state_next = dlb_pkg::S_GET_GO;
            dlb_pkg::S_PROD:      state_next = dlb_pkg::S_SUB;
            dlb_pkg::S_SUB:       state_next = dlb_pkg::S_DONE;
            dlb_pkg::S_DONE:      if (load_out) state_next = dlb_pkg::S_IDLE;
            default:              state_next = dlb_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake and unit strobes
    always_comb
    begin
        in_ready         = 1'b0;
        rm_start         = 1'b0;
        rm_x             = x_reg;
        rm_y             = y_reg;
        mm_start         = 1'b0;
        mm_a             = pw_reg;
        mm_b             = br_reg;
        tbl_req.start    = 1'b0;
        tbl_req.op       = dlb_pkg::TBL_GET;
        tbl_req.key      = pw_reg;
        tbl_req.exponent = cnt_reg[15:0];
        unique case (state_reg)
            dlb_pkg::S_IDLE:    in_ready = 1'b1;
            dlb_pkg::S_GCD_GO:  rm_start = (y_reg != 32'd0);
            dlb_pkg::S_REDB_GO:
            begin
                rm_start = 1'b1;
                rm_x     = base_reg;
                rm_y     = p_reg;
            end
            dlb_pkg::S_REDT_GO:
            begin
                rm_start = 1'b1;
                rm_x     = target_reg;
                rm_y     = p_reg;
            end
            dlb_pkg::S_CLR_GO:
            begin
                tbl_req.start = 1'b1;
                tbl_req.op    = dlb_pkg::TBL_CLEAR;
            end
            dlb_pkg::S_PUT_GO:
            begin
                tbl_req.start = 1'b1;
                tbl_req.op    = dlb_pkg::TBL_PUT;
            end
            dlb_pkg::S_BMUL_GO: mm_start = 1'b1;
            dlb_pkg::S_GF_GO:
            begin
                mm_start = 1'b1;
                mm_a     = gf_reg;
            end
            dlb_pkg::S_GET_GO:  tbl_req.start = 1'b1;
            dlb_pkg::S_GMUL_GO:
            begin
                mm_start = 1'b1;
                mm_b     = gf_reg;
            end
            default: ;
        endcase
    end

    // Output register: valid drops on a completed transaction unless reloaded
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlb_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.exponent <= res_exp_reg;
            out_data_reg.status   <= res_status_reg;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            dlb_pkg::S_IDLE:
            begin
                base_reg       <= in_data.base & dlb_pkg::MOD_MASK;
                target_reg     <= in_data.target & dlb_pkg::MOD_MASK;
                p_reg          <= in_mod;
                x_reg          <= in_mod;
                y_reg          <= in_data.base & dlb_pkg::MOD_MASK;
                res_exp_reg    <= 33'd0;
                res_status_reg <= dlb_pkg::ST_NOT_COPRIME;
            end
            dlb_pkg::S_GCD_WAIT:
            begin
                if (rm_done)
                begin
                    x_reg <= y_reg;
                    y_reg <= rm_result;
                end
            end
            dlb_pkg::S_REDB_WAIT:
            begin
                if (rm_done)
                    br_reg <= rm_result;
            end
            dlb_pkg::S_REDT_WAIT:
            begin
                if (rm_done)
                    tr_reg <= rm_result;
                sq_reg         <= 16'd0;
                sqb_reg        <= 4'd15;
                res_status_reg <= dlb_pkg::ST_NO_SOLUTION;
            end
            dlb_pkg::S_SQRT:
            begin
                sq_reg  <= sq_pick;
                sqb_reg <= sqb_reg - 4'd1;
                m_reg   <= {1'b0, sq_pick} + 17'd1;
            end
            dlb_pkg::S_CLR_WAIT:
            begin
                pw_reg  <= tr_reg;
                cnt_reg <= 17'd0;
            end
            dlb_pkg::S_PUT_WAIT:
            begin
                if (tbl_resp.done && baby_last)
                begin
                    gf_reg  <= (p_reg == 32'd1) ? 32'd0 : 32'd1;
                    cnt_reg <= 17'd0;
                end
            end
            dlb_pkg::S_BMUL_WAIT, dlb_pkg::S_GMUL_WAIT:
            begin
                if (mm_done)
                begin
                    pw_reg  <= mm_result;
                    cnt_reg <= cnt_reg + 17'd1;
                end
            end
            dlb_pkg::S_GF_WAIT:
            begin
                if (mm_done)
                begin
                    gf_reg  <= mm_result;
                    cnt_reg <= cnt_reg + 17'd1;
                end
            end
            dlb_pkg::S_GF_CHECK:
            begin
                // base^m vanishes: only a zero target has a solution
                if (gf_reg == 32'd0)
                begin
                    if (tr_reg == 32'd0)
                    begin
                        res_exp_reg    <= 33'd1;
                        res_status_reg <= dlb_pkg::ST_FOUND;
                    end
                end
                pw_reg  <= gf_reg;
                cnt_reg <= 17'd1;
            end
            dlb_pkg::S_GET_WAIT:
            begin
                if (tbl_resp.done && tbl_resp.hit)
                    hit_reg <= tbl_resp.exponent;
            end
            dlb_pkg::S_PROD:
                prod_reg <= {17'd0, cnt_reg} * {17'd0, m_reg};
            dlb_pkg::S_SUB:
            begin
                res_exp_reg    <= 33'(prod_reg - {18'd0, hit_reg});
                res_status_reg <= dlb_pkg::ST_FOUND;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hw/rtl/dlb_checker.sv
// Port-level checker for discrete_log_bsgs, bound to the top level.
// Depends on dlb_pkg and discrete_log_bsgs_macros.svh.
`include "discrete_log_bsgs_macros.svh"

module dlb_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input dlb_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input dlb_pkg::out_item_t out_data
);

    logic found;

    assign found = (out_data.status == dlb_pkg::ST_FOUND);

    // A waiting query holds
    `DLB_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

    // A stalled result holds
    `DLB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // The block is busy right after it takes a transaction
    `DLB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // Exponent is zero unless a solution was found
    `DLB_ASSERT_NOW(a_exp_zero, out_valid && !found, out_data.exponent == 33'd0)

    // A found solution is never exponent zero
    `DLB_ASSERT_NOW(a_found_nonzero, out_valid && found, out_data.exponent != 33'd0)

endmodule

bind discrete_log_bsgs dlb_checker u_dlb_checker (.*);
